// ----- rtl/sld_pkg.sv -----
// Shared constants and types for the sync/length/checksum deframer.
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int STORE_DEPTH = 32;
  localparam int LEN_LIMIT   = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 6;
  localparam int CNT_W       = 32;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ERR  = 1'b1;

  // Frame close event from the parser to the readout sequencer.
  typedef struct packed {
    logic             valid;
    logic             good;
    logic [LEN_W-1:0] len;
    logic             cv;
    logic [CNT_W-1:0] good_cnt;
    logic [CNT_W-1:0] bad_cnt;
  } sld_close_t;

endpackage

`default_nettype wire

// ----- rtl/sld_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sld_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sld_parse.sv -----
// Byte parser: sync hunt, length, payload store writes, checksum check, frame counters.
`timescale 1ns / 1ps
`default_nettype none

module sld_parse import sld_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  output logic                   wr_en,
  output logic      [ADDR_W-1:0] wr_addr,
  output logic      [7:0]        wr_data,
  output sld_close_t             close_r
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_LEN,
    PH_DATA,
    PH_CSUM
  } phase_t;

  phase_t           phase_r;
  logic [LEN_W-1:0] exp_len_r;
  logic [LEN_W-1:0] fill_r;
  logic [LEN_W-1:0] fill_nxt;
  logic [7:0]       sum_r;
  logic [CNT_W-1:0] good_r;
  logic [CNT_W-1:0] bad_r;
  logic             cnt_en_r;

  assign fill_nxt = fill_r + LEN_W'(1);
  assign wr_en    = acc && (phase_r == PH_DATA);
  assign wr_addr  = fill_r[ADDR_W-1:0];
  assign wr_data  = rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      exp_len_r     <= '0;
      fill_r        <= '0;
      sum_r         <= '0;
      good_r        <= '0;
      bad_r         <= '0;
      cnt_en_r      <= 1'b1;
      close_r       <= '0;
    end else begin
      close_r.valid <= 1'b0;
      if (cfg_we) begin
        cnt_en_r <= cfg_wdata;
      end
      if (acc) begin
        case (phase_r)
          PH_HUNT: begin
            if (rx_byte == SYNC_FIRST) phase_r <= PH_SYNC2;
          end
          PH_SYNC2: begin
            if (rx_byte == SYNC_SECOND) phase_r <= PH_LEN;
            else if (rx_byte != SYNC_FIRST) phase_r <= PH_HUNT;
          end
          PH_LEN: begin
            if (rx_byte == 8'd0 || rx_byte > 8'(LEN_LIMIT)) begin
              phase_r <= PH_HUNT;
            end else begin
              exp_len_r <= rx_byte[LEN_W-1:0];
              fill_r    <= '0;
              sum_r     <= rx_byte;
              phase_r   <= PH_DATA;
            end
          end
          PH_DATA: begin
            fill_r <= fill_nxt;
            sum_r  <= sum_r + rx_byte;
            if (fill_nxt >= exp_len_r) phase_r <= PH_CSUM;
          end
          PH_CSUM: begin
            phase_r       <= PH_HUNT;
            close_r.valid <= 1'b1;
            close_r.len   <= exp_len_r;
            close_r.cv    <= cnt_en_r && (exp_len_r >= LEN_W'(2));
            if (rx_byte == sum_r) begin
              good_r           <= good_r + CNT_W'(1);
              close_r.good     <= 1'b1;
              close_r.good_cnt <= good_r + CNT_W'(1);
              close_r.bad_cnt  <= bad_r;
            end else begin
              bad_r            <= bad_r + CNT_W'(1);
              close_r.good     <= 1'b0;
              close_r.good_cnt <= good_r;
              close_r.bad_cnt  <= bad_r + CNT_W'(1);
            end
          end
          default: begin
            phase_r <= PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sld_emit.sv -----
// Readout sequencer: walks the payload store after a good frame, output register.
`timescale 1ns / 1ps
`default_nettype none

module sld_emit import sld_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sld_close_t        close_i,
  output logic                   busy,
  output logic                   rd_en,
  output logic      [ADDR_W-1:0] rd_addr,
  input  wire logic [7:0]        rd_data,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [103:0]      out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  logic             busy_r;
  logic             run_r;
  logic             pend_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] idx_r;
  logic [ADDR_W-1:0] pidx_r;
  logic             cv_r;
  logic [CNT_W-1:0] good_r;
  logic [CNT_W-1:0] bad_r;
  logic [7:0]       b0_r;
  logic [7:0]       b1_r;
  logic             ov_r;
  logic             o_kind_r;
  logic [7:0]       o_data_r;
  logic [ADDR_W-1:0] o_pos_r;
  logic             o_last_r;
  logic             o_cv_r;
  logic [15:0]      o_cval_r;
  logic             p_last;
  logic [15:0]      cval_now;

  assign busy     = busy_r || close_i.valid;
  assign rd_en    = busy_r && run_r && !pend_r && (idx_r < len_r) && (!ov_r || out_tready);
  assign rd_addr  = idx_r[ADDR_W-1:0];
  assign p_last   = ({1'b0, pidx_r} + LEN_W'(1)) == len_r;
  assign cval_now = (pidx_r == ADDR_W'(1)) ? {b0_r, rd_data} : {b0_r, b1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      run_r  <= 1'b0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= rd_en;
      if (rd_en) begin
        pidx_r <= idx_r[ADDR_W-1:0];
        idx_r  <= idx_r + LEN_W'(1);
      end
      if (ov_r && out_tready) begin
        ov_r <= 1'b0;
        if (o_last_r) busy_r <= 1'b0;
      end
      if (close_i.valid) begin
        busy_r <= 1'b1;
        run_r  <= close_i.good;
        len_r  <= close_i.len;
        cv_r   <= close_i.cv;
        good_r <= close_i.good_cnt;
        bad_r  <= close_i.bad_cnt;
        idx_r  <= '0;
        if (!close_i.good) begin
          ov_r     <= 1'b1;
          o_kind_r <= KIND_ERR;
          o_data_r <= '0;
          o_pos_r  <= '0;
          o_last_r <= 1'b1;
          o_cv_r   <= 1'b0;
          o_cval_r <= '0;
        end
      end
      if (pend_r) begin
        ov_r     <= 1'b1;
        o_kind_r <= KIND_DATA;
        o_data_r <= rd_data;
        o_pos_r  <= pidx_r;
        o_last_r <= p_last;
        o_cv_r   <= p_last && cv_r;
        o_cval_r <= (p_last && cv_r) ? cval_now : 16'd0;
        if (pidx_r == ADDR_W'(0)) b0_r <= rd_data;
        if (pidx_r == ADDR_W'(1)) b1_r <= rd_data;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_kind_r;
  assign out_tdata  = {4'd0, bad_r, good_r, o_cval_r, o_cv_r, len_r, o_pos_r, o_data_r};

endmodule

`default_nettype wire

// ----- rtl/sync_length_checksum_deframer.sv -----
// Top level of the sync/length/checksum deframer.
//
//  channel | dir | handshake           | content
//  in_     | in  | in_tvalid/in_tready | tdata[7:0] rx_byte
//  out_    | out | out_tvalid/tready   | tdata, tlast = last_of_run, tuser = result_kind
//  cfg_    | in  | cfg_we              | cfg_wdata = counter_enable
//
// One input byte per cycle while parsing; in_tready drops from the checksum byte
// until the last result of that frame is taken.
// Readout reads each payload byte from the store, then loads it into the output register
// before the next read, so a frame blocks input through its readout plus output stalls.
// A checksum error gives one result, registered in the parser close event and then in the output register.
// Synchronous active-low reset; the payload store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_checksum_deframer import sld_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [7:0] data_byte, [12:8] byte_position, [18:13] frame_length, [19] counter_valid,
  // [35:20] counter_value, [67:36] good_frame_count, [99:68] bad_checksum_count
  output logic      [103:0] out_tdata,
  output logic              out_tlast,
  output logic              out_tuser,  // [0] result_kind
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata
);

  logic              acc;
  logic              busy;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  sld_close_t        close_ev;

  assign in_tready = !busy;
  assign acc       = in_tvalid && in_tready;

  sld_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .close_r   (close_ev)
  );

  sld_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sld_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .close_i    (close_ev),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/sld_checker.sv -----
// Port-level assertions for the deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sld_checker import sld_pkg::*; (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata,
  input wire logic         out_tlast,
  input wire logic         out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_no_input_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(in_tvalid && in_tready))
    else $error("input taken while results pending");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ERR) |->
      out_tlast && (out_tdata[12:0] == 13'd0) && !out_tdata[19])
    else $error("malformed error item");

  a_counter_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> out_tlast)
    else $error("counter_valid on a non-final item");

endmodule

bind sync_length_checksum_deframer sld_checker u_sld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
